// ----- hw/rtl/hts_pkg.sv -----
`default_nettype none

package hts_pkg;

  // field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned MODE_W  = 2;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_NORMAL        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL_TAGGED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SKIP          = 2'd2;

  // pattern lengths
  localparam logic [POS_W-1:0] OPEN_LEN  = 4'd7;
  localparam logic [POS_W-1:0] CLOSE_LEN = 4'd9;

  // characters
  localparam logic [BYTE_W-1:0] CHAR_LT       = 8'h3C;
  localparam logic [BYTE_W-1:0] CHAR_GT       = 8'h3E;
  localparam logic [BYTE_W-1:0] PRINTABLE_MIN = 8'h20;

  localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd4096;

  // "<script"
  function automatic logic [BYTE_W-1:0] open_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      4'd0:    c = 8'h3C;
      4'd1:    c = 8'h73;
      4'd2:    c = 8'h63;
      4'd3:    c = 8'h72;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h70;
      4'd6:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "</script>"
  function automatic logic [BYTE_W-1:0] close_char(input logic [POS_W-1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      4'd0:    c = 8'h3C;
      4'd1:    c = 8'h2F;
      4'd2:    c = 8'h73;
      4'd3:    c = 8'h63;
      4'd4:    c = 8'h72;
      4'd5:    c = 8'h69;
      4'd6:    c = 8'h70;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h3E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/html_tag_stripper.sv -----
// Throughput: one byte per cycle while the output is not stalled; the filter state
// updates in a single pass per byte and the output register takes the next result in
// the cycle it is drained. Each input transaction's result is registered there.
// Reset: synchronous, active-low rst_n clears filter state, empties the output
// register and sets output_limit to 4096.
`default_nettype none

module html_tag_stripper
  import hts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration write
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data,     // output_limit
  // input stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [BYTE_W-1:0]  in_tdata,     // [7:0] in_byte
  input  wire logic               in_tlast,     // in_last
  // result stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [BYTE_W-1:0]       out_tdata,    // [7:0] out_byte
  output logic [1:0]              out_tuser,    // [0] out_valid, [1] out_full
  output logic                    out_tlast     // out_end
);

  logic [COUNT_W-1:0] output_limit_r;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               inside_r, inside_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               stopped_r, stopped_nxt;

  logic               ovalid_r;
  logic [BYTE_W-1:0]  obyte_r, obyte_nxt;
  logic               opass_r, opass_nxt;
  logic               ofull_r;
  logic               oend_r;

  logic               accept;
  logic [BYTE_W-1:0]  b;

  assign cfg_ready = 1'b1;
  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign b         = in_tdata;

  // filter step for one byte
  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    inside_nxt  = inside_r;
    count_nxt   = count_r;
    stopped_nxt = stopped_r;
    opass_nxt   = 1'b0;
    obyte_nxt   = '0;
    if (!stopped_r) begin
      if (mode_r[1]) begin
        // skip mode: look for the closing tag
        if (pos_r < CLOSE_LEN && b == close_char(pos_r)) begin
          if (pos_r == CLOSE_LEN - 4'd1) begin
            mode_nxt = MODE_NORMAL;
            pos_nxt  = '0;
          end else begin
            pos_nxt = pos_r + 4'd1;
          end
        end else begin
          pos_nxt = (b == CHAR_LT) ? 4'd1 : 4'd0;
        end
      end else if (pos_r == OPEN_LEN - 4'd1 && b == open_char(OPEN_LEN - 4'd1)) begin
        // full opening tag: restore tag flag held before its '<'
        inside_nxt = (mode_r == MODE_NORMAL_TAGGED);
        mode_nxt   = MODE_SKIP;
        pos_nxt    = '0;
      end else begin
        if (pos_r != 4'd0 && pos_r < OPEN_LEN - 4'd1 && b == open_char(pos_r)) begin
          pos_nxt = pos_r + 4'd1;
        end else if (b == CHAR_LT) begin
          mode_nxt = inside_r ? MODE_NORMAL_TAGGED : MODE_NORMAL;
          pos_nxt  = 4'd1;
        end else begin
          mode_nxt = MODE_NORMAL;
          pos_nxt  = '0;
        end

        // tag tracking and pass decision
        if (b == CHAR_LT) begin
          inside_nxt = 1'b1;
        end else if (b == CHAR_GT) begin
          inside_nxt = 1'b0;
        end else if (!inside_r && b >= PRINTABLE_MIN) begin
          opass_nxt = 1'b1;
          obyte_nxt = b;
          count_nxt = count_r + 13'd1;
          if (count_nxt >= output_limit_r) begin
            stopped_nxt = 1'b1;
          end
        end
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      output_limit_r <= cfg_data;
    end
  end

  // filter state, cleared after the last byte of a text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_NORMAL;
      pos_r     <= '0;
      inside_r  <= 1'b0;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        mode_r    <= MODE_NORMAL;
        pos_r     <= '0;
        inside_r  <= 1'b0;
        count_r   <= '0;
        stopped_r <= 1'b0;
      end else begin
        mode_r    <= mode_nxt;
        pos_r     <= pos_nxt;
        inside_r  <= inside_nxt;
        count_r   <= count_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (accept) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      obyte_r <= obyte_nxt;
      opass_r <= opass_nxt;
      ofull_r <= stopped_nxt;
      oend_r  <= in_tlast;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = obyte_r;
  assign out_tuser  = {ofull_r, opass_r};
  assign out_tlast  = oend_r;

endmodule

`default_nettype wire

// ----- hw/rtl/hts_checker.sv -----
`default_nettype none

module hts_checker
  import hts_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [BYTE_W-1:0]  out_tdata,
  input wire logic [1:0]         out_tuser,
  input wire logic               out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // every input transaction produces a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transaction without result");

  // no new byte taken while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted over a stalled result");

  // dropped bytes read as zero, passed bytes are printable and not brackets
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] ? (out_tdata >= PRINTABLE_MIN && out_tdata != CHAR_LT &&
      out_tdata != CHAR_GT) : (out_tdata == '0)))
    else $error("bad result byte");

endmodule

bind html_tag_stripper hts_checker u_hts_checker (.*);

`default_nettype wire
